### hw/rtl/ipt_pkg.sv
`default_nettype none
package ipt_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam logic [15:0] Sat16 = 16'hFFFF;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChUnder = 8'h5F;

  typedef enum logic [1:0] {
    KIND_IDENT = 2'd0,
    KIND_PUNCT = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } token_kind_e;

  typedef struct packed {
    logic        has_ident;
    logic [15:0] ident_line;
    logic [15:0] ident_column;
    logic [15:0] ident_length;
    logic        has_tok;
    token_kind_e tok_kind;
    logic [7:0]  tok_char;
    logic [15:0] tok_line;
    logic [15:0] tok_column;
  } event_t;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [7:0]  token_char;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [15:0] token_length;
  } token_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == Sat16) ? v : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/identifier_punct_tokenizer_unit.sv
// channel   dir  tdata                                       tlast
// s_axis    in   [7:0] char_byte                             -
// m_axis    out  [1:0] token_kind, [9:2] token_char,         last_of_run
//                [25:10] token_line, [41:26] token_column,
//                [57:42] token_length, [63:58] zero
// One byte accepted per cycle while the four-entry event queue has room.
// A byte that closes an identifier and yields a second token gives two
// output tokens from one queue entry; every other result gives one.
// Reset: line 1, column 0, idle, queue empty. Halted after an error until reset.
// Output stalls back up through the queue to s_axis_tready only when full.
`default_nettype none
module identifier_punct_tokenizer_unit import ipt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // char_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // kind, char, line, column, length
  output logic             m_axis_tlast    // last_of_run
);

  logic   full, empty, push, pop, accept;
  event_t ev, head;
  token_t tok;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ipt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata),
    .push_o   (push),
    .event_o  (ev)
  );

  ipt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (ev),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  ipt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .token_o (tok),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, tok.token_length, tok.token_column, tok.token_line,
                         tok.token_char, tok.token_kind};

endmodule
`default_nettype wire

### hw/rtl/ipt_front.sv
`default_nettype none
module ipt_front import ipt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] char_i,
  output logic            push_o,
  output event_t          event_o
);

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_IDENT   = 4'b0010,
    MODE_COMMENT = 4'b0100,
    MODE_HALT    = 4'b1000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic [15:0] sline_q, sline_d;
  logic [15:0] scol_q, scol_d;
  logic [15:0] len_q, len_d;

  logic is_start, is_body, do_idle;

  assign is_start = (char_i >= 8'h61 && char_i <= 8'h7A) ||
                    (char_i >= 8'h41 && char_i <= 8'h5A) || (char_i == ChUnder);
  assign is_body  = is_start || (char_i >= 8'h30 && char_i <= 8'h39);

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    len_d   = len_q;
    do_idle = 1'b0;
    event_o = '0;
    event_o.ident_line   = sline_q;
    event_o.ident_column = scol_q;
    event_o.ident_length = len_q;
    event_o.tok_kind     = KIND_PUNCT;
    event_o.tok_char     = char_i;
    event_o.tok_line     = line_q;
    event_o.tok_column   = col_q;
    unique case (mode_q)
      MODE_HALT: begin
      end
      MODE_COMMENT: begin
        if (char_i == ChLf) begin
          line_d = sat_inc(line_q);
          col_d  = 16'd1;
          mode_d = MODE_IDLE;
        end else if (char_i == ChNul) begin
          event_o.has_tok  = 1'b1;
          event_o.tok_kind = KIND_END;
          col_d  = sat_inc(col_q);
          mode_d = MODE_IDLE;
        end else begin
          col_d = sat_inc(col_q);
        end
      end
      MODE_IDENT: begin
        if (is_body) begin
          len_d = sat_inc(len_q);
          col_d = sat_inc(col_q);
        end else begin
          event_o.has_ident = 1'b1;
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      MODE_IDLE: do_idle = 1'b1;
      default: begin
      end
    endcase

    if (do_idle) begin
      case (char_i)
        ChSpace, ChTab: col_d = sat_inc(col_q);
        ChLf: begin
          line_d = sat_inc(line_q);
          col_d  = 16'd1;
        end
        ChHash: begin
          col_d  = sat_inc(col_q);
          mode_d = MODE_COMMENT;
        end
        ChNul, ChStar, ChLpar, ChRpar, ChColon: begin
          event_o.has_tok  = 1'b1;
          event_o.tok_kind = (char_i == ChNul) ? KIND_END : KIND_PUNCT;
          col_d = sat_inc(col_q);
        end
        default: begin
          if (is_start) begin
            sline_d = line_q;
            scol_d  = col_q;
            len_d   = 16'd1;
            col_d   = sat_inc(col_q);
            mode_d  = MODE_IDENT;
          end else begin
            event_o.has_tok  = 1'b1;
            event_o.tok_kind = KIND_ERROR;
            mode_d = MODE_HALT;
          end
        end
      endcase
    end
  end

  assign push_o = accept_i && (event_o.has_ident || event_o.has_tok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= 16'd1;
      col_q   <= 16'd0;
      sline_q <= 16'd0;
      scol_q  <= 16'd0;
      len_q   <= 16'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      len_q   <= len_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ipt_queue.sv
`default_nettype none
module ipt_queue import ipt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  event_t      push_data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output event_t      head_o
);

  event_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, rd_q;
  logic [QueuePtrW:0]     cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ipt_back.sv
`default_nettype none
module ipt_back import ipt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   empty_i,
  input  event_t      head_i,
  output logic        pop_o,
  output logic        valid_o,
  input  wire logic   ready_i,
  output token_t      token_o,
  output logic        last_o
);

  logic phase_q;
  logic sel_ident, fire;

  assign sel_ident = head_i.has_ident && !phase_q;
  assign valid_o   = !empty_i;
  assign last_o    = !(sel_ident && head_i.has_tok);
  assign fire      = valid_o && ready_i;
  assign pop_o     = fire && last_o;

  always_comb begin
    if (sel_ident) begin
      token_o.token_kind   = KIND_IDENT;
      token_o.token_char   = 8'd0;
      token_o.token_line   = head_i.ident_line;
      token_o.token_column = head_i.ident_column;
      token_o.token_length = head_i.ident_length;
    end else begin
      token_o.token_kind   = head_i.tok_kind;
      token_o.token_char   = head_i.tok_char;
      token_o.token_line   = head_i.tok_line;
      token_o.token_column = head_i.tok_column;
      token_o.token_length = 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (fire) begin
      phase_q <= !last_o;
    end
  end

endmodule
`default_nettype wire
